// ===== rtl/gcsl_pkg.sv =====
// Shared types and character constants for the G-code serial line checker.
package gcsl_pkg;

  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChOne   = 8'h31;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChM     = 8'h4D;
  localparam logic [7:0] ChN     = 8'h4E;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChTab   = 8'h09;

  localparam logic [31:0] MagLimit = 32'h8000_0000;
  localparam logic [31:0] PosLimit = 32'h7FFF_FFFF;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NUM_ERR = 2'd1,
    ST_SUM_ERR = 2'd2,
    ST_NO_SUM  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_SC_RD,
    B_SC_USE,
    B_DECIDE,
    B_PA_RD,
    B_PA_USE,
    B_PA_END,
    B_ERR,
    B_EM_RD,
    B_EM_USE
  } back_state_t;

  function automatic logic is_blank(input logic [7:0] b);
    return (b == ChSpace) || (b >= ChTab && b <= ChCr);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= ChZero) && (b <= ChNine);
  endfunction

endpackage

// ===== rtl/gcsl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gcsl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/gcsl_front.sv =====
// Front end: accepts host bytes, handles escape and comment, fills the line store.
module gcsl_front #(
  parameter int LINE_BYTES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_rx_byte,
  input  logic                          back_busy,
  input  logic                          job_pop,
  output logic                          job_valid,
  output logic [$clog2(LINE_BYTES)-1:0] job_len,
  output logic                          we,
  output logic [$clog2(LINE_BYTES)-1:0] waddr,
  output logic [7:0]                    wdata
);
  import gcsl_pkg::*;

  localparam int FW = $clog2(LINE_BYTES);
  localparam logic [FW-1:0] FillMax = FW'(LINE_BYTES - 1);

  logic [FW-1:0] fill_r, fill_nxt;
  logic          cmt_r, cmt_nxt;
  logic          esc_r, esc_nxt;
  logic          jv_r, jv_nxt;
  logic [FW-1:0] jlen_r, jlen_nxt;
  logic          acc;

  assign in_stall = jv_r | back_busy;
  assign acc      = in_valid & ~in_stall;

  always_comb begin
    fill_nxt = fill_r;
    cmt_nxt  = cmt_r;
    esc_nxt  = esc_r;
    jv_nxt   = jv_r & ~job_pop;
    jlen_nxt = jlen_r;
    we       = 1'b0;
    if (acc) begin
      if (esc_r) begin
        esc_nxt = 1'b0;
        if (!cmt_r && fill_r < FillMax) begin
          we       = 1'b1;
          fill_nxt = fill_r + 1'b1;
        end
      end else if (in_rx_byte == ChLf || in_rx_byte == ChCr) begin
        cmt_nxt = 1'b0;
        if (fill_r != '0) begin
          jv_nxt   = 1'b1;
          jlen_nxt = fill_r;
          fill_nxt = '0;
        end
      end else if (fill_r >= FillMax) begin
        // drop bytes of an overlong line
      end else if (in_rx_byte == ChBslash) begin
        esc_nxt = 1'b1;
      end else if (in_rx_byte == ChSemi) begin
        cmt_nxt = 1'b1;
      end else if (!cmt_r) begin
        we       = 1'b1;
        fill_nxt = fill_r + 1'b1;
      end
    end
  end

  assign waddr     = fill_r;
  assign wdata     = in_rx_byte;
  assign job_valid = jv_r;
  assign job_len   = jlen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      cmt_r  <= 1'b0;
      esc_r  <= 1'b0;
      jv_r   <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      cmt_r  <= cmt_nxt;
      esc_r  <= esc_nxt;
      jv_r   <= jv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    jlen_r <= jlen_nxt;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n) fill_r <= FillMax)
    else $error("fill count beyond store");
  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (back_busy | jv_r) |-> !we)
    else $error("line store written while a line is checked");
  a_push_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(jv_r)) |-> (fill_r == '0))
    else $error("line handed over without clearing fill");

endmodule

// ===== rtl/gcsl_back.sv =====
// Back end: scans a stored line, checks number and checksum, emits results.
module gcsl_back #(
  parameter int LINE_BYTES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          job_valid,
  input  logic [$clog2(LINE_BYTES)-1:0] job_len,
  output logic                          job_pop,
  output logic                          back_busy,
  output logic [$clog2(LINE_BYTES)-1:0] raddr,
  input  logic [7:0]                    rdata,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output logic [7:0]                    out_line_byte,
  output logic                          out_last_of_line,
  output logic signed [31:0]            out_line_number
);
  import gcsl_pkg::*;

  localparam int FW = $clog2(LINE_BYTES);

  back_state_t   st_r, st_nxt;
  logic [FW-1:0] len_r, len_nxt, a_r, a_nxt;
  logic          seen_r, seen_nxt, numd_r, numd_nxt, semi_r, semi_nxt;
  logic [FW-1:0] c_r, c_nxt, rel_r, rel_nxt, npos_r, npos_nxt, star_r, star_nxt;
  logic [7:0]    h1_r, h1_nxt, h2_r, h2_nxt, h3_r, h3_nxt;
  logic          m110_r, m110_nxt, npf_r, npf_nxt, hstar_r, hstar_nxt;
  logic [7:0]    sum_r, sum_nxt, xr_r, xr_nxt;
  logic          neg_r, neg_nxt, dig_r, dig_nxt, ph_r, ph_nxt;
  logic [31:0]   mag_r, mag_nxt, num_r, num_nxt, lastn_r, lastn_nxt;
  status_t       err_r, err_nxt;

  logic          ov_r, ov_nxt, ol_r, ol_nxt;
  status_t       os_r, os_nxt;
  logic [7:0]    ob_r, ob_nxt;
  logic [31:0]   on_r, on_nxt;

  logic          out_free;
  logic [FW-1:0] rel_cur, base;
  logic [35:0]   mag_ext;
  logic [31:0]   val, next_num;

  assign out_free = ~ov_r | ~out_stall;
  assign next_num = lastn_r + 32'd1;
  assign rel_cur  = seen_r ? rel_r : '0;
  assign base     = (m110_r && npf_r) ? npos_r : c_r;
  assign mag_ext  = {1'b0, mag_r, 3'b000} + {3'b000, mag_r, 1'b0} + {28'd0, rdata - ChZero};
  assign val      = neg_r ? (32'd0 - mag_r) : ((mag_r > PosLimit) ? PosLimit : mag_r);

  always_comb begin
    st_nxt = st_r;  len_nxt = len_r;  a_nxt = a_r;
    seen_nxt = seen_r;  numd_nxt = numd_r;  semi_nxt = semi_r;
    c_nxt = c_r;  rel_nxt = rel_r;  npos_nxt = npos_r;  star_nxt = star_r;
    h1_nxt = h1_r;  h2_nxt = h2_r;  h3_nxt = h3_r;
    m110_nxt = m110_r;  npf_nxt = npf_r;  hstar_nxt = hstar_r;
    sum_nxt = sum_r;  xr_nxt = xr_r;
    neg_nxt = neg_r;  dig_nxt = dig_r;  ph_nxt = ph_r;
    mag_nxt = mag_r;  num_nxt = num_r;  lastn_nxt = lastn_r;  err_nxt = err_r;
    ov_nxt = ov_r & out_stall;
    os_nxt = os_r;  ob_nxt = ob_r;  ol_nxt = ol_r;  on_nxt = on_r;
    job_pop = 1'b0;
    case (st_r)
      B_IDLE: begin
        if (job_valid) begin
          job_pop   = 1'b1;
          len_nxt   = job_len;
          a_nxt     = '0;
          seen_nxt  = 1'b0;  numd_nxt = 1'b0;  semi_nxt = 1'b0;
          m110_nxt  = 1'b0;  npf_nxt  = 1'b0;  hstar_nxt = 1'b0;
          xr_nxt    = '0;    sum_nxt  = '0;    rel_nxt  = '0;
          c_nxt     = '0;    npos_nxt = '0;    star_nxt = '0;
          st_nxt    = B_SC_RD;
        end
      end
      B_SC_RD: st_nxt = B_SC_USE;
      B_SC_USE: begin
        if (a_r == '0) semi_nxt = (rdata == ChSemi);
        if (seen_r || rdata != ChSpace) begin
          if (!seen_r) begin
            seen_nxt = 1'b1;
            c_nxt    = a_r;
            numd_nxt = (rdata == ChN);
          end
          if (rdata == ChStar) begin
            star_nxt  = a_r;
            hstar_nxt = 1'b1;
            sum_nxt   = xr_r;
          end
          xr_nxt = xr_r ^ rdata;
          if (rel_cur >= FW'(3) && h3_r == ChM && h2_r == ChOne && h1_r == ChOne &&
              rdata == ChZero) begin
            m110_nxt = 1'b1;
          end
          if (rel_cur >= FW'(4) && rdata == ChN && !npf_r) begin
            npf_nxt  = 1'b1;
            npos_nxt = a_r;
          end
          h3_nxt  = h2_r;
          h2_nxt  = h1_r;
          h1_nxt  = rdata;
          rel_nxt = rel_cur + 1'b1;
        end
        if (a_r + 1'b1 == len_r) begin
          st_nxt = B_DECIDE;
        end else begin
          a_nxt  = a_r + 1'b1;
          st_nxt = B_SC_RD;
        end
      end
      B_DECIDE: begin
        if (numd_r) begin
          a_nxt   = base + 1'b1;
          neg_nxt = 1'b0;  dig_nxt = 1'b0;  mag_nxt = '0;  ph_nxt = 1'b0;
          st_nxt  = B_PA_RD;
        end else if (semi_r) begin
          st_nxt = B_IDLE;
        end else begin
          a_nxt  = '0;
          st_nxt = B_EM_RD;
        end
      end
      B_PA_RD: st_nxt = (a_r == len_r) ? B_PA_END : B_PA_USE;
      B_PA_USE: begin
        if (is_digit(rdata)) begin
          dig_nxt = 1'b1;
          mag_nxt = (mag_ext > {4'd0, MagLimit}) ? MagLimit : mag_ext[31:0];
          a_nxt   = a_r + 1'b1;
          st_nxt  = B_PA_RD;
        end else if (!dig_r && is_blank(rdata)) begin
          a_nxt  = a_r + 1'b1;
          st_nxt = B_PA_RD;
        end else if (!dig_r && (rdata == ChPlus || rdata == ChMinus)) begin
          neg_nxt = (rdata == ChMinus);
          dig_nxt = 1'b1;
          a_nxt   = a_r + 1'b1;
          st_nxt  = B_PA_RD;
        end else begin
          st_nxt = B_PA_END;
        end
      end
      B_PA_END: begin
        if (!ph_r) begin
          num_nxt = val;
          if (!m110_r && val != next_num) begin
            err_nxt = ST_NUM_ERR;
            st_nxt  = B_ERR;
          end else if (!hstar_r) begin
            err_nxt = ST_NO_SUM;
            st_nxt  = B_ERR;
          end else begin
            a_nxt   = star_r + 1'b1;
            neg_nxt = 1'b0;  dig_nxt = 1'b0;  mag_nxt = '0;  ph_nxt = 1'b1;
            st_nxt  = B_PA_RD;
          end
        end else if (val != {24'd0, sum_r}) begin
          err_nxt = ST_SUM_ERR;
          st_nxt  = B_ERR;
        end else begin
          lastn_nxt = num_r;
          a_nxt     = '0;
          st_nxt    = semi_r ? B_IDLE : B_EM_RD;
        end
      end
      B_ERR: begin
        if (out_free) begin
          ov_nxt = 1'b1;  os_nxt = err_r;  ob_nxt = '0;  ol_nxt = 1'b1;
          on_nxt = next_num;
          st_nxt = B_IDLE;
        end
      end
      B_EM_RD: st_nxt = B_EM_USE;
      B_EM_USE: begin
        if (out_free) begin
          ov_nxt = 1'b1;  os_nxt = ST_OK;  ob_nxt = rdata;
          ol_nxt = (a_r + 1'b1 == len_r);
          on_nxt = lastn_r;
          if (a_r + 1'b1 == len_r) begin
            st_nxt = B_IDLE;
          end else begin
            a_nxt  = a_r + 1'b1;
            st_nxt = B_EM_RD;
          end
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= B_IDLE;
      ov_r    <= 1'b0;
      lastn_r <= '0;
    end else begin
      st_r    <= st_nxt;
      ov_r    <= ov_nxt;
      lastn_r <= lastn_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r <= len_nxt;  a_r <= a_nxt;
    seen_r <= seen_nxt;  numd_r <= numd_nxt;  semi_r <= semi_nxt;
    c_r <= c_nxt;  rel_r <= rel_nxt;  npos_r <= npos_nxt;  star_r <= star_nxt;
    h1_r <= h1_nxt;  h2_r <= h2_nxt;  h3_r <= h3_nxt;
    m110_r <= m110_nxt;  npf_r <= npf_nxt;  hstar_r <= hstar_nxt;
    sum_r <= sum_nxt;  xr_r <= xr_nxt;
    neg_r <= neg_nxt;  dig_r <= dig_nxt;  ph_r <= ph_nxt;
    mag_r <= mag_nxt;  num_r <= num_nxt;  err_r <= err_nxt;
    os_r <= os_nxt;  ob_r <= ob_nxt;  ol_r <= ol_nxt;  on_r <= on_nxt;
  end

  assign back_busy        = (st_r != B_IDLE);
  assign raddr            = a_r;
  assign out_valid        = ov_r;
  assign out_status       = os_r;
  assign out_line_byte    = ob_r;
  assign out_last_of_line = ol_r;
  assign out_line_number  = on_r;

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && os_r != ST_OK) |-> (ol_r && ob_r == 8'd0))
    else $error("error result not final or carries a byte");
  a_idle_stays: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_IDLE && !job_valid) |=> (st_r == B_IDLE))
    else $error("back end left idle without a line");
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_SC_USE || st_r == B_EM_USE) |-> (a_r < len_r))
    else $error("read beyond line length");

endmodule

// ===== rtl/gcode_serial_line_checker.sv =====
// Top level of the G-code serial line checker: front end, line store, back end.
//
// Usage: host bytes enter on in_rx_byte (in_valid / in_stall). Bytes are
// collected into a line store; at CR or LF the finished line is handed to
// the back end, which checks it and emits results on the out_ channel
// (out_valid / out_stall): one item per line byte with status 0, or a single
// error item (status 1 number, 2 checksum, 3 no checksum) carrying the
// number to resend. out_last_of_line marks the final item of a line.
// A line of L bytes blocks input while checked: in_stall stays high from
// the handover until the back end is idle again. The check reads the line
// in passes: a scan of every byte, for a numbered line a parse of the
// number and one of the checksum, then a pass that emits the bytes. All
// passes share the single read port of the line store.
// Reset (rst_n low, synchronous) clears fill count, comment and escape
// state, the last line number and the output valid; the store is not
// cleared. A stalled output holds its item; the back end waits, and the
// input stays stalled until the line's last result is registered.
module gcode_serial_line_checker #(
  parameter int LINE_BYTES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [7:0]         out_line_byte,
  output logic               out_last_of_line,
  output logic signed [31:0] out_line_number
);
  import gcsl_pkg::*;

  localparam int FW = $clog2(LINE_BYTES);

  logic          back_busy, job_pop, job_valid, we;
  logic [FW-1:0] job_len, waddr, raddr;
  logic [7:0]    wdata, rdata;

  // collect bytes and hand over finished lines
  gcsl_front #(.LINE_BYTES(LINE_BYTES)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_rx_byte,
    .back_busy, .job_pop, .job_valid, .job_len,
    .we, .waddr, .wdata
  );

  // line store, written by the front, read by the back
  gcsl_ram #(.WIDTH(8), .DEPTH(LINE_BYTES)) u_store (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  // check the line and deliver items
  gcsl_back #(.LINE_BYTES(LINE_BYTES)) u_back (
    .clk, .rst_n, .job_valid, .job_len, .job_pop, .back_busy,
    .raddr, .rdata,
    .out_valid, .out_stall, .out_status, .out_line_byte,
    .out_last_of_line, .out_line_number
  );

  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    back_busy |-> in_stall)
    else $error("input open while a line is checked");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |=> back_busy)
    else $error("line taken without starting the check");
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> (job_valid && !back_busy))
    else $error("pop of an empty handover");

endmodule
